/* rtl/core/head_length_tail_deframer_assert.svh */
// Assertion macros shared by the deframer RTL.
`ifndef HEAD_LENGTH_TAIL_DEFRAMER_ASSERT_SVH
`define HEAD_LENGTH_TAIL_DEFRAMER_ASSERT_SVH

// Same-cycle implication, sampled on the rising edge of clk and held off during reset.
`define HLTD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising edge of clk and held off during reset.
`define HLTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/hltd_pkg.sv */
// Types and constants of the header/length/trailer deframer.
package hltd_pkg;

  localparam int BYTE_W       = 8;
  localparam int LEN_W        = 19;
  localparam int CFG_W        = 64;
  localparam int CFG_IDX_W    = 3;
  localparam int HEAD_LEN_W   = 4;
  localparam int TAIL_LEN_W   = 4;
  localparam int DIGIT_CNT_W  = 3;
  localparam int KIND_W       = 2;
  localparam int TAIL_SEL_W   = 3;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_LEN,
    PH_PAY,
    PH_TAIL
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_PAYLOAD   = 2'd0,
    KIND_TAIL_GOOD = 2'd1,
    KIND_TAIL_BAD  = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEAD_PATTERN = 3'd0,
    REG_HEAD_LEN     = 3'd1,
    REG_TAIL_PATTERN = 3'd2,
    REG_TAIL_LEN     = 3'd3,
    REG_DIGIT_COUNT  = 3'd4
  } reg_idx_t;

endpackage

/* rtl/core/head_length_tail_deframer.sv */
// Header/length/trailer deframer: an input register, one step of frame logic, a result register.
//
// Bytes enter on in_valid/in_stall with in_byte; a request is taken at a rising
// edge where in_valid is high and in_stall is low. The block hunts for the
// configured header, reads the length digits, passes the payload bytes out and
// checks the trailer, then sends a frame end marker with the decoded length.
// Results leave on out_valid/out_stall with out_kind, out_byte and frame_length.
// Registers are written on cfg_valid/cfg_ready with cfg_index and cfg_data.
// The configuration channel is always ready.
// An accepted byte passes the input register and then the result register. One byte is taken
// every cycle unless the receiver stalls, because each byte needs one window compare and one
// small state update between the input register and the result register.
// While the receiver stalls a waiting result, the result register holds it and
// a byte in the input register waits with in_stall high. An empty input
// register still takes one more byte, and after that in_stall rises.
// Reset is synchronous. It empties both registers, restores the register reset
// values and starts a header hunt. No clearing pass is needed.
`include "head_length_tail_deframer_assert.svh"

module head_length_tail_deframer
  import hltd_pkg::*;
#(
  parameter int MAX_HEAD_BYTES = 8,
  parameter int MAX_TAIL_BYTES = 8,
  parameter int MAX_LEN_DIGITS = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    in_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [KIND_W-1:0]    out_kind,
  output logic [BYTE_W-1:0]    out_byte,
  output logic [LEN_W-1:0]     frame_length,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int HW = $clog2(MAX_HEAD_BYTES + 1);
  localparam int IW = (MAX_HEAD_BYTES > 1) ? $clog2(MAX_HEAD_BYTES) : 1;
  localparam int TW = $clog2(MAX_TAIL_BYTES + 1);
  localparam int DW = $clog2(MAX_LEN_DIGITS + 1);

  logic [CFG_W-1:0]       head_pattern;
  logic [HEAD_LEN_W-1:0]  head_len;
  logic [CFG_W-1:0]       tail_pattern;
  logic [TAIL_LEN_W-1:0]  tail_len;
  logic [DIGIT_CNT_W-1:0] digit_count;

  logic                   in_reg_valid;
  logic [BYTE_W-1:0]      in_reg_byte;
  logic                   advance;
  logic                   step;

  phase_t                 phase, phase_next;
  logic [BYTE_W-1:0]      window [MAX_HEAD_BYTES];
  logic [BYTE_W-1:0]      window_next [MAX_HEAD_BYTES];
  logic [HW-1:0]          window_fill, window_fill_next;
  logic [LEN_W-1:0]       phase_count, phase_count_next;
  logic [LEN_W-1:0]       length_value, length_value_next;
  logic                   tail_good, tail_good_next;

  logic [HW-1:0]          eff_head;
  logic [TW-1:0]          eff_tail;
  logic [DW-1:0]          eff_digits;

  logic [HW-1:0]          hunt_base;
  logic [HW-1:0]          hunt_fill;
  logic                   head_match;
  logic                   head_hit;
  logic [LEN_W-1:0]       count_inc;
  logic [LEN_W-1:0]       length_mac;
  logic                   tail_byte_ok;
  logic                   tail_seen_all;
  logic                   tail_last;

  logic                   res_valid;
  kind_t                  res_kind;
  logic [BYTE_W-1:0]      res_byte;
  logic [LEN_W-1:0]       res_len;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_pattern <= '0;
      head_len     <= HEAD_LEN_W'(1);
      tail_pattern <= '0;
      tail_len     <= '0;
      digit_count  <= DIGIT_CNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HEAD_PATTERN: head_pattern <= cfg_data;
        REG_HEAD_LEN:     head_len     <= cfg_data[HEAD_LEN_W-1:0];
        REG_TAIL_PATTERN: tail_pattern <= cfg_data;
        REG_TAIL_LEN:     tail_len     <= cfg_data[TAIL_LEN_W-1:0];
        REG_DIGIT_COUNT:  digit_count  <= cfg_data[DIGIT_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Register values are clamped to the ranges that the logic supports.
  always_comb begin
    if (head_len == '0) begin
      eff_head = HW'(1);
    end else if (head_len > HEAD_LEN_W'(MAX_HEAD_BYTES)) begin
      eff_head = HW'(MAX_HEAD_BYTES);
    end else begin
      eff_head = HW'(head_len);
    end
    if (tail_len > TAIL_LEN_W'(MAX_TAIL_BYTES)) begin
      eff_tail = TW'(MAX_TAIL_BYTES);
    end else begin
      eff_tail = TW'(tail_len);
    end
    if (digit_count == '0) begin
      eff_digits = DW'(1);
    end else if (digit_count > DIGIT_CNT_W'(MAX_LEN_DIGITS)) begin
      eff_digits = DW'(MAX_LEN_DIGITS);
    end else begin
      eff_digits = DW'(digit_count);
    end
  end

  // Input register.
  assign advance  = !out_valid || !out_stall;
  assign in_stall = in_reg_valid && !advance;
  assign step     = in_reg_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg_byte <= in_byte;
    end
  end

  // Header window. The newest byte sits in the top entry.
  always_comb begin
    for (int j = 0; j < MAX_HEAD_BYTES - 1; j++) begin
      window_next[j] = window[j+1];
    end
    window_next[MAX_HEAD_BYTES-1] = in_reg_byte;
  end

  // A frame end in the trailer phase restarts the hunt with an empty window.
  assign hunt_base = (phase == PH_TAIL) ? '0 : window_fill;
  assign hunt_fill = (hunt_base == HW'(MAX_HEAD_BYTES)) ? hunt_base : hunt_base + HW'(1);

  always_comb begin
    logic [IW-1:0] idx;
    head_match = 1'b1;
    for (int k = 0; k < MAX_HEAD_BYTES; k++) begin
      idx = IW'(MAX_HEAD_BYTES - int'(eff_head) + k);
      if (HW'(k) < eff_head) begin
        if (window_next[idx] != head_pattern[8*k +: 8]) begin
          head_match = 1'b0;
        end
      end
    end
  end

  assign head_hit = (hunt_fill >= eff_head) && head_match;

  assign count_inc     = phase_count + LEN_W'(1);
  assign length_mac    = (length_value << 3) + (length_value << 1) + LEN_W'(in_reg_byte);
  assign tail_byte_ok  = tail_pattern[8*phase_count[TAIL_SEL_W-1:0] +: 8] == in_reg_byte;
  assign tail_seen_all = phase_count >= LEN_W'(eff_tail);
  assign tail_last     = count_inc >= LEN_W'(eff_tail);

  // Next state.
  always_comb begin
    phase_next        = phase;
    phase_count_next  = phase_count;
    length_value_next = length_value;
    tail_good_next    = tail_good;
    window_fill_next  = window_fill;
    unique case (phase)
      PH_HUNT: begin
        window_fill_next = hunt_fill;
        if (head_hit) begin
          phase_next        = PH_LEN;
          phase_count_next  = '0;
          length_value_next = '0;
          window_fill_next  = '0;
        end
      end
      PH_LEN: begin
        length_value_next = length_mac;
        phase_count_next  = count_inc;
        if (count_inc >= LEN_W'(eff_digits)) begin
          phase_count_next = '0;
          if (length_mac == '0) begin
            phase_next     = PH_TAIL;
            tail_good_next = 1'b1;
          end else begin
            phase_next = PH_PAY;
          end
        end
      end
      PH_PAY: begin
        phase_count_next = count_inc;
        if (count_inc >= length_value) begin
          phase_next       = PH_TAIL;
          phase_count_next = '0;
          tail_good_next   = 1'b1;
        end
      end
      PH_TAIL: begin
        if (tail_seen_all) begin
          phase_next       = PH_HUNT;
          phase_count_next = '0;
          window_fill_next = hunt_fill;
          if (head_hit) begin
            phase_next        = PH_LEN;
            length_value_next = '0;
            window_fill_next  = '0;
          end
        end else begin
          tail_good_next   = tail_good && tail_byte_ok;
          phase_count_next = count_inc;
          if (tail_last) begin
            phase_next       = PH_HUNT;
            phase_count_next = '0;
            window_fill_next = '0;
          end
        end
      end
    endcase
  end

  // Result of the current byte.
  always_comb begin
    res_valid = 1'b0;
    res_kind  = KIND_PAYLOAD;
    res_byte  = '0;
    res_len   = '0;
    unique case (phase)
      PH_HUNT: ;
      PH_LEN:  ;
      PH_PAY: begin
        res_valid = 1'b1;
        res_byte  = in_reg_byte;
      end
      PH_TAIL: begin
        if (tail_seen_all) begin
          res_valid = 1'b1;
          res_kind  = tail_good ? KIND_TAIL_GOOD : KIND_TAIL_BAD;
          res_len   = length_value;
        end else if (tail_last) begin
          res_valid = 1'b1;
          res_kind  = (tail_good && tail_byte_ok) ? KIND_TAIL_GOOD : KIND_TAIL_BAD;
          res_len   = length_value;
        end
      end
    endcase
  end

  // Frame state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      phase_count  <= '0;
      length_value <= '0;
      tail_good    <= 1'b1;
      window_fill  <= '0;
    end else if (step) begin
      phase        <= phase_next;
      phase_count  <= phase_count_next;
      length_value <= length_value_next;
      tail_good    <= tail_good_next;
      window_fill  <= window_fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      for (int j = 0; j < MAX_HEAD_BYTES; j++) begin
        window[j] <= window_next[j];
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_kind     <= res_kind;
      out_byte     <= res_byte;
      frame_length <= res_len;
    end
  end

  `HLTD_ASSERT_NOW(a_pay_has_length, phase == PH_PAY, length_value != '0, "zero payload length")
  `HLTD_ASSERT_NOW(a_tail_count_bound, phase == PH_TAIL, phase_count <= LEN_W'(MAX_TAIL_BYTES), "bad count")
  `HLTD_ASSERT_NOW(a_marker_fields, out_valid && (out_kind != KIND_PAYLOAD), out_byte == '0, "marker byte")
  `HLTD_ASSERT_NEXT(a_held_byte_kept, in_reg_valid && !advance, in_reg_valid && $stable(in_reg_byte), "lost")

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the header/length/trailer deframer with a byte-level frame predictor.
module testbench;
  import hltd_pkg::*;

  localparam int MAX_HEAD = 8;
  localparam int MAX_TAIL = 8;
  localparam int MAX_DIGITS = 4;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    kind_t            kind;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  length;
  } frame_out_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [BYTE_W-1:0]    in_byte = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [KIND_W-1:0]    out_kind;
  logic [BYTE_W-1:0]    out_byte;
  logic [LEN_W-1:0]     frame_length;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  logic [63:0] cfg_head_pat = '0;
  logic [3:0]  cfg_head_len = 4'd1;
  logic [63:0] cfg_tail_pat = '0;
  logic [3:0]  cfg_tail_len = 4'd0;
  logic [2:0]  cfg_digits = 3'd1;

  phase_t           ph = PH_HUNT;
  logic [63:0]      win = '0;
  int unsigned      win_fill = 0;
  logic [LEN_W-1:0] ph_count = '0;
  logic [LEN_W-1:0] frame_len = '0;
  logic             trailer_ok = 1'b1;

  logic [BYTE_W-1:0] send_bytes[$];
  frame_out_t        frame_outs_due[$];
  frame_out_t        want;

  int unsigned fed_count = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned gap_max = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_left = 0;
  int unsigned holds_done = 0;
  int unsigned err_count = 0;
  int unsigned cycles = 0;

  head_length_tail_deframer i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .out_byte     (out_byte),
    .frame_length (frame_length),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic int unsigned eff_head_len();
    if (cfg_head_len == 0) return 1;
    if (cfg_head_len > MAX_HEAD) return MAX_HEAD;
    return cfg_head_len;
  endfunction

  function automatic int unsigned eff_tail_len();
    if (cfg_tail_len > MAX_TAIL) return MAX_TAIL;
    return cfg_tail_len;
  endfunction

  function automatic int unsigned eff_digit_count();
    if (cfg_digits == 0) return 1;
    if (cfg_digits > MAX_DIGITS) return MAX_DIGITS;
    return cfg_digits;
  endfunction

  task automatic hunt_step(input logic [7:0] b);
    int unsigned hl;
    logic [63:0] mask;
    hl = eff_head_len();
    win = {b, win[63:8]};
    if (win_fill < 8) win_fill++;
    if (win_fill >= hl) begin
      mask = (hl >= 8) ? '1 : ((64'd1 << (8 * hl)) - 64'd1);
      if ((win >> (64 - 8 * hl)) == (cfg_head_pat & mask)) begin
        ph = PH_LEN;
        ph_count = '0;
        frame_len = '0;
        win_fill = 0;
        win = '0;
      end
    end
  endtask

  task automatic close_frame();
    frame_out_t r;
    r.kind = trailer_ok ? KIND_TAIL_GOOD : KIND_TAIL_BAD;
    r.data = '0;
    r.length = frame_len;
    frame_outs_due.push_back(r);
    ph = PH_HUNT;
    ph_count = '0;
    win_fill = 0;
    win = '0;
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    frame_out_t r;
    int unsigned tl;
    tl = eff_tail_len();
    case (ph)
      PH_HUNT: hunt_step(b);
      PH_LEN: begin
        frame_len = frame_len * 19'd10 + 19'(b);
        ph_count = ph_count + 19'd1;
        if (ph_count >= eff_digit_count()) begin
          ph_count = '0;
          if (frame_len == '0) begin
            ph = PH_TAIL;
            trailer_ok = 1'b1;
          end else begin
            ph = PH_PAY;
          end
        end
      end
      PH_PAY: begin
        r.kind = KIND_PAYLOAD;
        r.data = b;
        r.length = '0;
        frame_outs_due.push_back(r);
        ph_count = ph_count + 19'd1;
        if (ph_count >= frame_len) begin
          ph = PH_TAIL;
          ph_count = '0;
          trailer_ok = 1'b1;
        end
      end
      default: begin
        if (ph_count >= tl) begin
          close_frame();
          hunt_step(b);
        end else begin
          if (cfg_tail_pat[8 * ph_count[2:0] +: 8] != b) trailer_ok = 1'b0;
          ph_count = ph_count + 19'd1;
          if (ph_count >= tl) close_frame();
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        deframe_byte(in_byte);
        fed_count <= fed_count + 1;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (send_bytes.size() != 0) begin
          in_valid <= 1'b1;
          in_byte <= send_bytes.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 32);
            gap_left = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (frame_outs_due.size() == 0) begin
          err_count++;
          if (err_count <= 10) begin
            $display("unexpected result: kind %0d byte %02h length %0d",
                     out_kind, out_byte, frame_length);
          end
        end else begin
          want = frame_outs_due.pop_front();
          if (out_kind !== want.kind || out_byte !== want.data ||
              frame_length !== want.length) begin
            err_count++;
            if (err_count <= 10) begin
              $display("mismatch: expected kind %0d byte %02h length %0d, got kind %0d byte %02h length %0d",
                       want.kind, want.data, want.length, out_kind, out_byte, frame_length);
            end
          end
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < stall_pct);
    end
  end

  // The receiver holds off twice for a long stretch while bytes keep coming.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done < 2 && in_valid && fed_count >= 400 + 900 * holds_done) begin
      hold_left <= 150;
      holds_done <= holds_done + 1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [63:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_HEAD_PATTERN: cfg_head_pat = value;
      REG_HEAD_LEN:     cfg_head_len = value[3:0];
      REG_TAIL_PATTERN: cfg_tail_pat = value;
      REG_TAIL_LEN:     cfg_tail_len = value[3:0];
      REG_DIGIT_COUNT:  cfg_digits = value[2:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    do begin
      do @(negedge clk);
      while (send_bytes.size() != 0 || in_valid || frame_outs_due.size() != 0);
      repeat (6) @(posedge clk);
      @(negedge clk);
    end while (frame_outs_due.size() != 0);
  endtask

  // Queues a frame or broken header for current settings; n counts all but leading noise bytes.
  task automatic queue_frame(output int unsigned n);
    int unsigned hl, tl, d, flen, p, i, k, bad_pos;
    logic big, bad_tail;
    logic [7:0] b;
    hl = eff_head_len();
    tl = eff_tail_len();
    d = eff_digit_count();
    n = 0;
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 4)) send_bytes.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 9) == 0) begin
      bad_pos = $urandom_range(0, hl - 1);
      for (i = 0; i <= bad_pos; i++) begin
        b = cfg_head_pat[8 * i +: 8];
        if (i == bad_pos) b = b ^ 8'($urandom_range(1, 255));
        send_bytes.push_back(b);
      end
      n = bad_pos + 1;
      return;
    end
    for (i = 0; i < hl; i++) send_bytes.push_back(cfg_head_pat[8 * i +: 8]);
    big = ($urandom_range(0, 29) == 0);
    if (big) flen = $urandom_range(200, 255);
    else if ($urandom_range(0, 7) == 0) flen = 0;
    else flen = $urandom_range(0, (d == 1) ? 9 : 24);
    for (k = 0; k < d; k++) begin
      p = 1;
      repeat (d - 1 - k) p = p * 10;
      if (big) b = (k == d - 1) ? 8'(flen) : 8'h00;
      else b = 8'((flen / p) % 10);
      send_bytes.push_back(b);
    end
    repeat (flen) send_bytes.push_back(8'($urandom_range(0, 255)));
    bad_tail = ($urandom_range(0, 4) == 0);
    bad_pos = (tl == 0) ? 0 : $urandom_range(0, tl - 1);
    for (i = 0; i < tl; i++) begin
      b = cfg_tail_pat[8 * i +: 8];
      if (bad_tail && i == bad_pos) b = b ^ 8'($urandom_range(1, 255));
      send_bytes.push_back(b);
    end
    n = hl + d + flen + tl;
  endtask

  initial begin
    int unsigned rand_items, n;
    logic [63:0] value;
    rand_items = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Single-byte header, one digit, no trailer: zero length and end markers on header bytes.
    write_reg(REG_HEAD_PATTERN, 64'h0000_0000_0000_00C3);
    write_reg(REG_HEAD_LEN, 64'd1);
    write_reg(REG_TAIL_PATTERN, 64'h0);
    write_reg(REG_TAIL_LEN, 64'd0);
    write_reg(REG_DIGIT_COUNT, 64'd1);
    @(negedge clk);
    send_bytes = '{8'h00, 8'hC3, 8'h00, 8'hC3, 8'h01, 8'hFF, 8'hC3, 8'h02, 8'h00, 8'h80,
                   8'h01};
    drain();

    // Two-byte header and trailer, two digits: zero length with trailer, then a bad trailer.
    write_reg(REG_HEAD_PATTERN, 64'h0000_0000_0000_5AA5);
    write_reg(REG_HEAD_LEN, 64'd2);
    write_reg(REG_TAIL_PATTERN, 64'h0000_0000_0000_0D0A);
    write_reg(REG_TAIL_LEN, 64'd2);
    write_reg(REG_DIGIT_COUNT, 64'd2);
    @(negedge clk);
    send_bytes = '{8'hA5, 8'h5A, 8'h00, 8'h00, 8'h0A, 8'h0D,
                   8'hA5, 8'h5A, 8'h00, 8'h01, 8'h7F, 8'h0A, 8'h0E};
    drain();

    while (rand_items < 2000) begin
      case ($urandom_range(0, 7))
        0: value = '0;
        1: value = '1;
        default: value = {$urandom, $urandom};
      endcase
      write_reg(REG_HEAD_PATTERN, value);
      value = {$urandom, $urandom};
      case ($urandom_range(0, 5))
        0: value[3:0] = 4'd0;
        1: value[3:0] = 4'd1;
        2: value[3:0] = 4'd8;
        3: value[3:0] = 4'($urandom_range(9, 15));
        default: value[3:0] = 4'($urandom_range(1, 8));
      endcase
      write_reg(REG_HEAD_LEN, value);
      write_reg(REG_TAIL_PATTERN, ($urandom_range(0, 7) == 0) ? '1 : {$urandom, $urandom});
      value = {$urandom, $urandom};
      case ($urandom_range(0, 4))
        0: value[3:0] = 4'd0;
        1: value[3:0] = 4'd8;
        2: value[3:0] = 4'($urandom_range(9, 15));
        default: value[3:0] = 4'($urandom_range(0, 8));
      endcase
      write_reg(REG_TAIL_LEN, value);
      value = {$urandom, $urandom};
      case ($urandom_range(0, 5))
        0: value[2:0] = 3'd0;
        1: value[2:0] = 3'd1;
        2: value[2:0] = 3'd4;
        3: value[2:0] = 3'($urandom_range(5, 7));
        default: value[2:0] = 3'($urandom_range(1, 4));
      endcase
      write_reg(REG_DIGIT_COUNT, value);
      @(negedge clk);
      case ($urandom_range(0, 3))
        0: begin gap_max = 0; stall_pct = 0; end
        1: begin gap_max = 3; stall_pct = 10; end
        2: begin gap_max = 8; stall_pct = 40; end
        default: begin gap_max = 2; stall_pct = 75; end
      endcase
      repeat ($urandom_range(3, 10)) begin
        queue_frame(n);
        rand_items += n;
      end
      // Ending in mid-frame makes the next settings apply to a frame already under way.
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 8)) begin
          if (send_bytes.size() != 0) void'(send_bytes.pop_back());
        end
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
